// ===== hdl/chtl_pkg.sv =====
// ----------------------------------------------------------------------------
// chtl_pkg
// Types and constants shared by the canonical Huffman table lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chtl_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_DEPTH = 256;

  localparam int IDX_W  = $clog2(MAX_CODE_LEN);
  localparam int LP_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int SL_W   = $clog2(SYMBOL_DEPTH + 1);
  localparam int EXP_W  = SL_W + 1;
  localparam int ADDR_W = $clog2(SYMBOL_DEPTH);

  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;
  localparam int SYM_W  = 8;
  localparam int RC_W   = CODE_W + 1;
  localparam int SIDX_W = CODE_W + 1;

  localparam logic [RC_W-1:0]   RC_MAX = {RC_W{1'b1}};
  localparam logic [CODE_W-1:0] FC_MAX = {CODE_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  data_byte;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] symbol;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } lookup_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0]  data;
  } store_wr_t;

endpackage

`default_nettype wire

// ===== hdl/chtl_ram.sv =====
// ----------------------------------------------------------------------------
// chtl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chtl_table.sv =====
// ----------------------------------------------------------------------------
// chtl_table
// Per-length code table: builds first codes, counts and symbol starts from
// the count bytes, steers symbol bytes to the store, and resolves lookups
// to a store address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chtl_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire chtl_pkg::in_item_t  item,
  input  wire logic                go,
  output chtl_pkg::lookup_t        lookup,
  output chtl_pkg::store_wr_t      wr
);

  localparam int MCL = chtl_pkg::MAX_CODE_LEN;
  localparam int IW  = chtl_pkg::IDX_W;
  localparam int LW  = chtl_pkg::LP_W;
  localparam int SW  = chtl_pkg::SL_W;
  localparam int EW  = chtl_pkg::EXP_W;
  localparam int CW  = chtl_pkg::CODE_W;
  localparam int RW  = chtl_pkg::RC_W;
  localparam int XW  = chtl_pkg::SIDX_W;
  localparam int NW  = chtl_pkg::LEN_W;
  localparam int YW  = chtl_pkg::SYM_W;
  localparam int AW  = chtl_pkg::ADDR_W;

  logic [YW-1:0] counts_r [MCL];
  logic [YW-1:0] counts_nxt [MCL];
  logic [CW-1:0] firsts_r [MCL];
  logic [CW-1:0] firsts_nxt [MCL];
  logic [SW-1:0] starts_r [MCL];
  logic [SW-1:0] starts_nxt [MCL];

  logic [LW-1:0] lp_r, lp_nxt;
  logic [RW-1:0] rc_r, rc_nxt;
  logic [SW-1:0] sl_r, sl_nxt;
  logic [SW-1:0] exp_r, exp_nxt;

  logic          is_load;
  logic          is_start;
  logic          counts_phase;
  logic [IW-1:0] wi;
  logic [RW:0]   rc_sum;
  logic [RW+1:0] rc_shift;
  logic [EW-1:0] exp_sum;

  assign is_load      = go && (item.cmd == chtl_pkg::CMD_LOAD);
  assign is_start     = go && (item.cmd == chtl_pkg::CMD_START);
  assign counts_phase = lp_r < LW'(MCL);
  assign wi           = lp_r[IW-1:0];

  assign rc_sum   = {1'b0, rc_r} + (RW + 1)'(item.data_byte);
  assign rc_shift = {rc_sum, 1'b0};
  assign exp_sum  = {1'b0, exp_r} + EW'(item.data_byte);

  assign wr.we   = is_load && !counts_phase && (sl_r < exp_r);
  assign wr.addr = sl_r[AW-1:0];
  assign wr.data = item.data_byte;

  always_comb begin
    counts_nxt = counts_r;
    firsts_nxt = firsts_r;
    starts_nxt = starts_r;
    lp_nxt     = lp_r;
    rc_nxt     = rc_r;
    sl_nxt     = sl_r;
    exp_nxt    = exp_r;
    if (is_start) begin
      for (int k = 0; k < MCL; k++) begin
        counts_nxt[k] = '0;
        firsts_nxt[k] = '0;
        starts_nxt[k] = '0;
      end
      lp_nxt  = '0;
      rc_nxt  = '0;
      sl_nxt  = '0;
      exp_nxt = '0;
    end else if (is_load && counts_phase) begin
      counts_nxt[wi] = item.data_byte;
      firsts_nxt[wi] = (rc_r > RW'(chtl_pkg::FC_MAX)) ? chtl_pkg::FC_MAX : rc_r[CW-1:0];
      starts_nxt[wi] = exp_r;
      rc_nxt  = (rc_shift > (RW + 2)'(chtl_pkg::RC_MAX)) ? chtl_pkg::RC_MAX
                                                          : rc_shift[RW-1:0];
      exp_nxt = (exp_sum > EW'(chtl_pkg::SYMBOL_DEPTH)) ? SW'(chtl_pkg::SYMBOL_DEPTH)
                                                         : exp_sum[SW-1:0];
      lp_nxt  = lp_r + LW'(1);
    end else if (wr.we) begin
      sl_nxt = sl_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MCL; k++) begin
        counts_r[k] <= '0;
        firsts_r[k] <= '0;
        starts_r[k] <= '0;
      end
      lp_r  <= '0;
      rc_r  <= '0;
      sl_r  <= '0;
      exp_r <= '0;
    end else begin
      counts_r <= counts_nxt;
      firsts_r <= firsts_nxt;
      starts_r <= starts_nxt;
      lp_r     <= lp_nxt;
      rc_r     <= rc_nxt;
      sl_r     <= sl_nxt;
      exp_r    <= exp_nxt;
    end
  end

  // lookup: pick the length row, check range, form the store index
  logic [NW-1:0] len;
  logic          len_ok;
  logic          too_wide;
  logic [IW-1:0] li;
  logic [CW-1:0] first;
  logic [CW-1:0] off;
  logic [XW-1:0] sidx;

  assign len      = item.code_length;
  assign len_ok   = (len != '0) && (len <= NW'(MCL));
  assign too_wide = (item.code_bits >> len) != '0;
  assign li       = IW'(len - NW'(1));
  assign first    = firsts_r[li];
  assign off      = item.code_bits - first;
  assign sidx     = XW'(starts_r[li]) + XW'(off);

  assign lookup.hit = len_ok && !too_wide && (item.code_bits >= first)
                      && (off < CW'(counts_r[li]))
                      && (sidx < XW'(sl_r))
                      && (sidx < XW'(chtl_pkg::SYMBOL_DEPTH));
  assign lookup.addr = sidx[AW-1:0];

`ifndef SYNTHESIS
  a_loaded_le_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sl_r <= exp_r)
    else $error("more symbols stored than the counts call for");

  a_symbols_after_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (sl_r != '0) |-> (lp_r == LW'(MCL)))
    else $error("symbols stored before all counts arrived");

  a_expected_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    exp_r <= SW'(chtl_pkg::SYMBOL_DEPTH))
    else $error("expected symbol total beyond store depth");
`endif

endmodule

`default_nettype wire

// ===== hdl/canonical_huffman_table_lookup_top.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_table_lookup_top
// Canonical Huffman decode table: loads count and symbol bytes, answers
// code lookups with a found flag and the symbol.
// ----------------------------------------------------------------------------
//  channel  ports                        payload     moves
//  in       in_valid/in_ready/in_data    in_item_t   start, load or lookup
//  out      out_valid/out_ready/out_data out_item_t  lookup result
//
//  one request per cycle while no lookup waits on a stalled output; a lookup result
//  passes the input register and then the registered read of the symbol store
//  start and load requests produce no result and retire from the input stage
//  reset clears the table and counters; the symbol store is not cleared
//  a stalled result holds in the output stage while one more request waits
//  in the input stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module canonical_huffman_table_lookup_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire chtl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output chtl_pkg::out_item_t      out_data
);

  chtl_pkg::in_item_t  s1_r;
  logic                s1_valid_r;
  logic                s2_valid_r;
  logic                found_r;

  chtl_pkg::lookup_t   lk;
  chtl_pkg::store_wr_t wr;

  logic                        s1_lookup;
  logic                        advance;
  logic                        s1_go;
  logic                        re;
  logic [chtl_pkg::SYM_W-1:0]  q;

  assign s1_lookup = s1_r.cmd == chtl_pkg::CMD_LOOKUP;
  assign advance   = !s2_valid_r || out_ready;
  // only lookups need room in the output stage
  assign s1_go     = s1_valid_r && (!s1_lookup || advance);
  assign in_ready  = !s1_valid_r || s1_go;
  assign re        = s1_go && s1_lookup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        s2_valid_r <= re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (re) begin
      found_r <= lk.hit;
    end
  end

  chtl_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_r),
    .go     (s1_go),
    .lookup (lk),
    .wr     (wr)
  );

  chtl_ram #(
    .WIDTH (chtl_pkg::SYM_W),
    .DEPTH (chtl_pkg::SYMBOL_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (re),
    .raddr (lk.addr),
    .rdata (q)
  );

  assign out_valid       = s2_valid_r;
  assign out_data.found  = found_r;
  assign out_data.symbol = found_r ? q : '0;

`ifndef SYNTHESIS
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.we && re))
    else $error("store written and read by the same request");

  a_result_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a request in the input stage");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire
